[rtl/fya_pkg.sv]
// ---------------------------------------------------------------------------
// fya_pkg: shared types and constants of the Feynman-Y window analyzer
// Field widths, function and status codes, datapath command and status types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fya_pkg;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int T_W      = 48;
  localparam int CH_W     = 8;
  localparam int CFG_W    = 40;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 32;
  localparam int CHC_W    = 16;
  localparam int PS_W     = 64;
  localparam int FIX_W    = 40;
  localparam int FRAC_W   = 16;
  localparam int SLOTS    = 4;
  localparam int PACK_W   = SLOTS * CHC_W;

  // block parameters
  localparam int CHANNELS    = 4;
  localparam int MAX_CLOSE   = 16;
  localparam int CLOSE_CNT_W = $clog2(MAX_CLOSE + 1);

  // shared divider
  localparam int DIV_W  = 64;
  localparam int STEP_W = $clog2(DIV_W);

  // configuration
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_LEN = 1'b1;
  localparam logic [CFG_W-1:0] WIN_LEN_RST  = 40'd1000000;
  localparam logic [CFG_W-1:0] GATE_LEN_RST = 40'd1000;

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_EVENT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_SUMMARY   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REJ_EVENT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REJ_CLOSE = 2'd2;

  // datapath operations
  typedef logic [4:0] dp_op_t;
  localparam dp_op_t OP_NOP        = 5'd0;
  localparam dp_op_t OP_LATCH      = 5'd1;
  localparam dp_op_t OP_CLEAR_ALL  = 5'd2;
  localparam dp_op_t OP_ANCHOR_EV  = 5'd3;
  localparam dp_op_t OP_ANCHOR_CL  = 5'd4;
  localparam dp_op_t OP_DIV_K      = 5'd5;
  localparam dp_op_t OP_SAVE_K     = 5'd6;
  localparam dp_op_t OP_SET_END_EV = 5'd7;
  localparam dp_op_t OP_SET_END_CL = 5'd8;
  localparam dp_op_t OP_MUL        = 5'd9;
  localparam dp_op_t OP_FOLD       = 5'd10;
  localparam dp_op_t OP_DIV_GATES  = 5'd11;
  localparam dp_op_t OP_SAVE_GATES = 5'd12;
  localparam dp_op_t OP_DIV_MEAN   = 5'd13;
  localparam dp_op_t OP_SAVE_MEAN  = 5'd14;
  localparam dp_op_t OP_DIV_Q      = 5'd15;
  localparam dp_op_t OP_SAVE_Q     = 5'd16;
  localparam dp_op_t OP_DIV_FRAC   = 5'd17;
  localparam dp_op_t OP_SAVE_FRAC  = 5'd18;
  localparam dp_op_t OP_EMIT_SUM   = 5'd19;
  localparam dp_op_t OP_EMIT_REJ   = 5'd20;
  localparam dp_op_t OP_WB_REM     = 5'd21;
  localparam dp_op_t OP_DIV_GATE   = 5'd22;
  localparam dp_op_t OP_SAVE_GATE  = 5'd23;
  localparam dp_op_t OP_REC_VALID  = 5'd24;
  localparam dp_op_t OP_REC_INVAL  = 5'd25;

  typedef struct packed {
    dp_op_t op;
    logic   div_start;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              rej_event;
    logic              rej_close;
    logic              span_ge_w;
    logic              t_le_wb;
    logic              ch_valid;
    logic              div_busy;
    logic              div_done;
    logic              s_zero;
    logic              q_big;
    logic              last_close;
    logic              ev_path;
    logic              out_free;
  } dp_status_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [T_W-1:0]          win_start;
    logic [T_W-1:0]          win_end;
    logic [PACK_W-1:0]       channel_counts;
    logic [CNT_W-1:0]        accepted_count;
    logic [CNT_W-1:0]        ignored_count;
    logic [FIX_W-1:0]        mean_mult;
    logic signed [FIX_W-1:0] y_excess;
    logic [CNT_W-1:0]        skipped_windows;
    logic                    last;
  } out_item_t;

endpackage

[rtl/fya_if.sv]
// ---------------------------------------------------------------------------
// fya_if: stream channels of the Feynman-Y window analyzer
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fya_in_if import fya_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [T_W-1:0]    time_us;
  logic [CH_W-1:0]   channel;

  modport source (output valid, output func, output time_us, output channel, input ready);
  modport sink   (input valid, input func, input time_us, input channel, output ready);
endinterface

interface fya_out_if import fya_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [T_W-1:0]          win_start;
  logic [T_W-1:0]          win_end;
  logic [PACK_W-1:0]       channel_counts;
  logic [CNT_W-1:0]        accepted_count;
  logic [CNT_W-1:0]        ignored_count;
  logic [FIX_W-1:0]        mean_mult;
  logic signed [FIX_W-1:0] y_excess;
  logic [CNT_W-1:0]        skipped_windows;
  logic                    last;

  modport source (output valid, output status, output win_start, output win_end,
                  output channel_counts, output accepted_count, output ignored_count,
                  output mean_mult, output y_excess, output skipped_windows,
                  output last, input ready);
  modport sink   (input valid, input status, input win_start, input win_end,
                  input channel_counts, input accepted_count, input ignored_count,
                  input mean_mult, input y_excess, input skipped_windows,
                  input last, output ready);
endinterface

[rtl/feynman_y_window_analyzer_top.sv]
// ---------------------------------------------------------------------------
// feynman_y_window_analyzer_top: Feynman-Y window analyzer
// An event that closes no window needs at most one gate division.
// Each window summary costs 2 to 4 shared-divider passes.
// One transaction is handled at a time, paced by the bit-serial divider.
// Reset: synchronous active-low rst_n clears the result valid flag and the window
// state except end_r, and loads window 1000000 us and gate 1000 us.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module feynman_y_window_analyzer_top import fya_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  fya_in_if.sink               in_ch,
  fya_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t st;
  out_item_t  item;
  logic       in_ready;
  logic       out_valid;

  fya_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  fya_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_func    (in_ch.func),
    .in_time_us (in_ch.time_us),
    .in_channel (in_ch.channel),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .out_item   (item)
  );

  // channel hookup
  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid;
  assign out_ch.status          = item.status;
  assign out_ch.win_start       = item.win_start;
  assign out_ch.win_end         = item.win_end;
  assign out_ch.channel_counts  = item.channel_counts;
  assign out_ch.accepted_count  = item.accepted_count;
  assign out_ch.ignored_count   = item.ignored_count;
  assign out_ch.mean_mult       = item.mean_mult;
  assign out_ch.y_excess        = item.y_excess;
  assign out_ch.skipped_windows = item.skipped_windows;
  assign out_ch.last            = item.last;

endmodule

[rtl/fya_div.sv]
// ---------------------------------------------------------------------------
// fya_div: shared restoring divider
// One quotient bit per cycle; quotient and remainder hold until next start.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fya_div import fya_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder
);

  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r;
  logic [DIV_W:0]    shifted, trial;

  // one restoring step
  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    if (!trial[DIV_W]) begin
      rem_nxt = trial[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[rtl/fya_datapath.sv]
// ---------------------------------------------------------------------------
// fya_datapath: window state, statistics arithmetic and result register
// Executes one controller operation per cycle; owns the shared divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fya_datapath import fya_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_status_t           st,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [T_W-1:0]       in_time_us,
  input  logic [CH_W-1:0]      in_channel,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item
);

  localparam logic signed [57:0] Y_HI = 58'sh7F_FFFF_FFFF;
  localparam logic signed [57:0] Y_LO = -58'sh80_0000_0000;
  localparam logic [FIX_W-1:0]   Y_MAX = {1'b0, {(FIX_W-1){1'b1}}};

  // configuration and latched item
  logic [CFG_W-1:0]  win_len_r, gate_len_r;
  logic [FUNC_W-1:0] func_r;
  logic [T_W-1:0]    t_r;
  logic [CH_W-1:0]   ch_r;

  // window state
  logic                 anchored_r, held_r;
  logic [T_W-1:0]       wb_r, latest_r, end_r;
  logic [FIX_W-1:0]     gi_r;
  logic [CNT_W-1:0]     gt_r, vt_r, it_r;
  logic [PS_W-1:0]      ps_r, prod_r;
  logic [CHC_W-1:0]     chan_r [SLOTS];

  // per-close scratch
  logic                   ev_path_r;
  logic [T_W-1:0]         k_r, gates_r, mean_r, gate_r;
  logic [CFG_W-1:0]       krem_r;
  logic [CLOSE_CNT_W-1:0] cnt_r, m_r;
  logic [FIX_W-1:0]       q_r;
  logic [CNT_W-1:0]       r_r;
  logic signed [FIX_W-1:0] y_r;

  // result register
  logic      out_valid_r;
  out_item_t out_r;

  // derived values
  logic [CFG_W-1:0]    w_eff, g_raw, g_eff;
  logic [T_W-1:0]      span, len, rest;
  logic [T_W:0]        len_up;
  logic                last_close, out_free, ch_ok;
  logic [1:0]          ch_idx;
  logic [PACK_W-1:0]   packed_cnt;
  logic [CNT_W-1:0]    skip_sat;
  logic signed [57:0]  y_diff;
  logic [PS_W:0]       ps_sum;
  logic [DIV_W-1:0]    dv_a, dv_b, dv_q, dv_r;
  logic                dv_busy, dv_done;

  always_comb begin
    w_eff = (win_len_r == '0) ? CFG_W'(1) : win_len_r;
    g_raw = (gate_len_r == '0) ? CFG_W'(1) : gate_len_r;
    g_eff = (g_raw < w_eff) ? g_raw : w_eff;
    span  = t_r - wb_r;
    len   = end_r - wb_r;
    len_up = {1'b0, len} + {9'b0, g_eff} - (T_W+1)'(1);
    ch_ok = (ch_r >= CH_W'(1)) && (ch_r <= CH_W'(CHANNELS));
    ch_idx = 2'(ch_r - CH_W'(1));
    last_close = (cnt_r == m_r - CLOSE_CNT_W'(1));
    rest = k_r - T_W'(m_r);
    skip_sat = (|rest[T_W-1:CNT_W]) ? '1 : rest[CNT_W-1:0];
    out_free = !out_valid_r || out_ready;
    ps_sum = {1'b0, ps_r} + {1'b0, prod_r};
    y_diff = $signed({2'b00, q_r, dv_q[FRAC_W-1:0]}) - $signed({10'b0, mean_r});
    for (int i = 0; i < SLOTS; i++) packed_cnt[i*CHC_W +: CHC_W] = chan_r[i];
  end

  // divider operand select
  always_comb begin
    dv_a = '0;
    dv_b = DIV_W'(1);
    case (cmd.op)
      OP_DIV_K:     begin dv_a = DIV_W'(span);  dv_b = DIV_W'(w_eff); end
      OP_DIV_GATES: begin dv_a = DIV_W'(len_up); dv_b = DIV_W'(g_eff); end
      OP_DIV_MEAN:  begin dv_a = DIV_W'({vt_r, 16'b0}); dv_b = DIV_W'(gates_r); end
      OP_DIV_Q:     begin dv_a = ps_r; dv_b = DIV_W'(vt_r); end
      OP_DIV_FRAC:  begin dv_a = DIV_W'({r_r, 16'b0}); dv_b = DIV_W'(vt_r); end
      OP_DIV_GATE:  begin dv_a = DIV_W'(span);  dv_b = DIV_W'(g_eff); end
      default: ;
    endcase
  end

  fya_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (dv_a),
    .divisor   (dv_b),
    .busy      (dv_busy),
    .done      (dv_done),
    .quotient  (dv_q),
    .remainder (dv_r)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r  <= WIN_LEN_RST;
      gate_len_r <= GATE_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIN_LEN:  win_len_r  <= cfg_wdata;
        CFG_GATE_LEN: gate_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // window state and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchored_r <= 1'b0;
      held_r     <= 1'b0;
      wb_r       <= '0;
      latest_r   <= '0;
      gi_r       <= '0;
      gt_r       <= '0;
      ps_r       <= '0;
      vt_r       <= '0;
      it_r       <= '0;
      for (int i = 0; i < SLOTS; i++) chan_r[i] <= '0;
      ev_path_r  <= 1'b0;
      cnt_r      <= '0;
      m_r        <= CLOSE_CNT_W'(1);
    end else begin
      unique case (cmd.op)
        OP_CLEAR_ALL: begin
          anchored_r <= 1'b0;
          wb_r       <= '0;
          latest_r   <= '0;
          held_r     <= 1'b0;
          gi_r       <= '0;
          gt_r       <= '0;
          ps_r       <= '0;
          vt_r       <= '0;
          it_r       <= '0;
          for (int i = 0; i < SLOTS; i++) chan_r[i] <= '0;
        end
        OP_ANCHOR_EV: begin
          if (!anchored_r) begin
            anchored_r <= 1'b1;
            wb_r       <= t_r;
          end
        end
        OP_ANCHOR_CL: begin
          if (!anchored_r) begin
            anchored_r <= 1'b1;
            wb_r       <= (t_r >= T_W'(w_eff)) ? t_r - T_W'(w_eff) : '0;
          end
        end
        OP_SAVE_K: begin
          cnt_r <= '0;
          m_r   <= (dv_q < DIV_W'(MAX_CLOSE)) ? dv_q[CLOSE_CNT_W-1:0]
                                              : CLOSE_CNT_W'(MAX_CLOSE);
        end
        OP_SET_END_EV: ev_path_r <= 1'b1;
        OP_SET_END_CL: ev_path_r <= 1'b0;
        OP_FOLD: begin
          ps_r <= ps_sum[PS_W] ? '1 : ps_sum[PS_W-1:0];
          gt_r <= '0;
        end
        OP_EMIT_SUM: begin
          // window closed: next starts at its end
          wb_r   <= end_r;
          held_r <= 1'b0;
          gi_r   <= '0;
          gt_r   <= '0;
          ps_r   <= '0;
          vt_r   <= '0;
          it_r   <= '0;
          for (int i = 0; i < SLOTS; i++) chan_r[i] <= '0;
          if (ev_path_r) cnt_r <= cnt_r + 1'b1;
        end
        OP_WB_REM: wb_r <= t_r - T_W'(krem_r);
        OP_REC_VALID: begin
          held_r   <= 1'b1;
          latest_r <= t_r;
          if (chan_r[ch_idx] != '1) chan_r[ch_idx] <= chan_r[ch_idx] + 1'b1;
          if (vt_r != '1) vt_r <= vt_r + 1'b1;
          if (gate_r > T_W'(gi_r)) begin
            ps_r <= ps_sum[PS_W] ? '1 : ps_sum[PS_W-1:0];
            gi_r <= gate_r[FIX_W-1:0];
            gt_r <= CNT_W'(1);
          end else if (gt_r != '1) begin
            gt_r <= gt_r + 1'b1;
          end
        end
        OP_REC_INVAL: begin
          held_r   <= 1'b1;
          latest_r <= t_r;
          if (it_r != '1) it_r <= it_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // scratch registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        func_r <= in_func;
        t_r    <= in_time_us;
        ch_r   <= in_channel;
      end
      OP_SAVE_K: begin
        k_r    <= dv_q[T_W-1:0];
        krem_r <= dv_r[CFG_W-1:0];
      end
      OP_SET_END_EV: end_r <= wb_r + T_W'(w_eff);
      OP_SET_END_CL: end_r <= t_r;
      OP_MUL:        prod_r <= gt_r * (gt_r - CNT_W'(1));
      OP_SAVE_GATES: gates_r <= dv_q[T_W-1:0];
      OP_SAVE_MEAN: begin
        mean_r <= dv_q[T_W-1:0];
        y_r    <= '0;
      end
      OP_SAVE_Q: begin
        q_r <= dv_q[FIX_W-1:0];
        r_r <= dv_r[CNT_W-1:0];
        if (|dv_q[DIV_W-1:FIX_W]) y_r <= Y_MAX;
      end
      OP_SAVE_FRAC: begin
        if (y_diff > Y_HI)      y_r <= Y_MAX;
        else if (y_diff < Y_LO) y_r <= ~Y_MAX;
        else                    y_r <= y_diff[FIX_W-1:0];
      end
      OP_SAVE_GATE: gate_r <= dv_q[T_W-1:0];
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT_SUM || cmd.op == OP_EMIT_REJ) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT_SUM) begin
      out_r.status          <= STAT_SUMMARY;
      out_r.win_start       <= wb_r;
      out_r.win_end         <= end_r;
      out_r.channel_counts  <= packed_cnt;
      out_r.accepted_count  <= vt_r;
      out_r.ignored_count   <= it_r;
      out_r.mean_mult       <= (|mean_r[T_W-1:FIX_W]) ? '1 : mean_r[FIX_W-1:0];
      out_r.y_excess        <= y_r;
      out_r.skipped_windows <= (ev_path_r && last_close) ? skip_sat : '0;
      out_r.last            <= !ev_path_r || last_close;
    end else if (cmd.op == OP_EMIT_REJ) begin
      // reject: only status and last are set
      out_r <= '{status: (func_r == FUNC_EVENT) ? STAT_REJ_EVENT : STAT_REJ_CLOSE,
                 last: 1'b1, default: '0};
    end
  end

  // status to controller
  always_comb begin
    st.func       = func_r;
    st.rej_event  = (held_r && t_r < latest_r) || (anchored_r && t_r < wb_r);
    st.rej_close  = held_r && t_r <= latest_r;
    st.span_ge_w  = span >= T_W'(w_eff);
    st.t_le_wb    = t_r <= wb_r;
    st.ch_valid   = ch_ok;
    st.div_busy   = dv_busy;
    st.div_done   = dv_done;
    st.s_zero     = vt_r == '0;
    st.q_big      = |dv_q[DIV_W-1:FIX_W];
    st.last_close = last_close;
    st.ev_path    = ev_path_r;
    st.out_free   = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

[rtl/fya_ctrl.sv]
// ---------------------------------------------------------------------------
// fya_ctrl: sequencer of the Feynman-Y window analyzer
// Walks each transaction through clear, reject, or anchor, window closes and event recording.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fya_ctrl import fya_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DECODE   = 5'd1;
  localparam logic [4:0] S_REJ      = 5'd2;
  localparam logic [4:0] S_EV_CHK   = 5'd3;
  localparam logic [4:0] S_EV_KWAIT = 5'd4;
  localparam logic [4:0] S_EV_END   = 5'd5;
  localparam logic [4:0] S_CL_CHK   = 5'd6;
  localparam logic [4:0] S_FOLD_MUL = 5'd7;
  localparam logic [4:0] S_FOLD_ADD = 5'd8;
  localparam logic [4:0] S_G_START  = 5'd9;
  localparam logic [4:0] S_G_WAIT   = 5'd10;
  localparam logic [4:0] S_M_START  = 5'd11;
  localparam logic [4:0] S_M_WAIT   = 5'd12;
  localparam logic [4:0] S_Q_START  = 5'd13;
  localparam logic [4:0] S_Q_WAIT   = 5'd14;
  localparam logic [4:0] S_F_START  = 5'd15;
  localparam logic [4:0] S_F_WAIT   = 5'd16;
  localparam logic [4:0] S_EMIT     = 5'd17;
  localparam logic [4:0] S_EV_WB    = 5'd18;
  localparam logic [4:0] S_REC      = 5'd19;
  localparam logic [4:0] S_R_WAIT   = 5'd20;
  localparam logic [4:0] S_R_MUL    = 5'd21;
  localparam logic [4:0] S_R_UPD    = 5'd22;

  logic [4:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd.op        = OP_NOP;
    cmd.div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.func)
          FUNC_CLEAR: begin
            cmd.op    = OP_CLEAR_ALL;
            state_nxt = S_IDLE;
          end
          FUNC_EVENT: begin
            if (st.rej_event) begin
              state_nxt = S_REJ;
            end else begin
              cmd.op    = OP_ANCHOR_EV;
              state_nxt = S_EV_CHK;
            end
          end
          FUNC_CLOSE: begin
            if (st.rej_close) begin
              state_nxt = S_REJ;
            end else begin
              cmd.op    = OP_ANCHOR_CL;
              state_nxt = S_CL_CHK;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_REJ: begin
        if (st.out_free) begin
          cmd.op    = OP_EMIT_REJ;
          state_nxt = S_IDLE;
        end
      end
      S_EV_CHK: begin
        if (st.span_ge_w) begin
          cmd.op        = OP_DIV_K;
          cmd.div_start = 1'b1;
          state_nxt     = S_EV_KWAIT;
        end else begin
          state_nxt = S_REC;
        end
      end
      S_EV_KWAIT: begin
        if (st.div_done) begin
          cmd.op    = OP_SAVE_K;
          state_nxt = S_EV_END;
        end
      end
      S_EV_END: begin
        cmd.op    = OP_SET_END_EV;
        state_nxt = S_FOLD_MUL;
      end
      S_CL_CHK: begin
        if (st.t_le_wb) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_SET_END_CL;
          state_nxt = S_FOLD_MUL;
        end
      end
      S_FOLD_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_FOLD_ADD;
      end
      S_FOLD_ADD: begin
        cmd.op    = OP_FOLD;
        state_nxt = S_G_START;
      end
      S_G_START: begin
        cmd.op        = OP_DIV_GATES;
        cmd.div_start = 1'b1;
        state_nxt     = S_G_WAIT;
      end
      S_G_WAIT: begin
        if (st.div_done) begin
          cmd.op    = OP_SAVE_GATES;
          state_nxt = S_M_START;
        end
      end
      S_M_START: begin
        cmd.op        = OP_DIV_MEAN;
        cmd.div_start = 1'b1;
        state_nxt     = S_M_WAIT;
      end
      S_M_WAIT: begin
        if (st.div_done) begin
          cmd.op    = OP_SAVE_MEAN;
          state_nxt = st.s_zero ? S_EMIT : S_Q_START;
        end
      end
      S_Q_START: begin
        cmd.op        = OP_DIV_Q;
        cmd.div_start = 1'b1;
        state_nxt     = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        if (st.div_done) begin
          cmd.op    = OP_SAVE_Q;
          state_nxt = st.q_big ? S_EMIT : S_F_START;
        end
      end
      S_F_START: begin
        cmd.op        = OP_DIV_FRAC;
        cmd.div_start = 1'b1;
        state_nxt     = S_F_WAIT;
      end
      S_F_WAIT: begin
        if (st.div_done) begin
          cmd.op    = OP_SAVE_FRAC;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.op = OP_EMIT_SUM;
          if (!st.ev_path)        state_nxt = S_IDLE;
          else if (st.last_close) state_nxt = S_EV_WB;
          else                    state_nxt = S_EV_END;
        end
      end
      S_EV_WB: begin
        cmd.op    = OP_WB_REM;
        state_nxt = S_REC;
      end
      S_REC: begin
        if (st.ch_valid) begin
          cmd.op        = OP_DIV_GATE;
          cmd.div_start = 1'b1;
          state_nxt     = S_R_WAIT;
        end else begin
          cmd.op    = OP_REC_INVAL;
          state_nxt = S_IDLE;
        end
      end
      S_R_WAIT: begin
        if (st.div_done) begin
          cmd.op    = OP_SAVE_GATE;
          state_nxt = S_R_MUL;
        end
      end
      S_R_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_R_UPD;
      end
      S_R_UPD: begin
        cmd.op    = OP_REC_VALID;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // checks
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DECODE)
    else $error("accepted transaction not decoded");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT_SUM || cmd.op == OP_EMIT_REJ) |-> st.out_free)
    else $error("result loaded while output register full");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !st.div_busy)
    else $error("divider started while busy");

  a_gates_to_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_G_WAIT && st.div_done) |=> state_r == S_M_START)
    else $error("gate count not followed by mean division");

endmodule
